@@ hdl/bblur_pkg.sv @@
// shared constants, types and tables of the 3x3 box blur
`default_nettype none

package bblur_pkg;

  // image limits
  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 4096;

  // field and register widths
  localparam int COL_W      = 10;
  localparam int ROW_W      = 12;
  localparam int WID_W      = 11;
  localparam int HGT_W      = 13;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 13;
  localparam int CH_W       = 8;
  localparam int PIX_W      = 3 * CH_W;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'b1;

  // input word function codes
  localparam logic FUNC_PIXEL = 1'b0;
  localparam logic FUNC_DRAIN = 1'b1;

  // arithmetic widths: sum of up to nine channels, count of up to nine
  localparam int SUM_W  = 12;
  localparam int CNT_W  = 4;
  localparam int DIV_W  = SUM_W + 1;
  localparam int RCP_SH = 24;
  localparam int RCP_W  = 24;
  localparam int PROD_W = DIV_W + RCP_W;

  // ceil(2^RCP_SH / (2n)), exact floor division for dividends below 2^13
  localparam logic [RCP_W-1:0] RCP_TAB [16] = '{
    RCP_W'(0),
    RCP_W'((2**RCP_SH + 1) / 2),
    RCP_W'((2**RCP_SH + 3) / 4),
    RCP_W'((2**RCP_SH + 5) / 6),
    RCP_W'((2**RCP_SH + 7) / 8),
    RCP_W'((2**RCP_SH + 9) / 10),
    RCP_W'((2**RCP_SH + 11) / 12),
    RCP_W'((2**RCP_SH + 13) / 14),
    RCP_W'((2**RCP_SH + 15) / 16),
    RCP_W'((2**RCP_SH + 17) / 18),
    RCP_W'(0), RCP_W'(0), RCP_W'(0), RCP_W'(0), RCP_W'(0), RCP_W'(0)
  };

  // command queue
  localparam int QD  = 2;
  localparam int QAW = (QD > 1) ? $clog2(QD) : 1;

  typedef enum logic {
    CMD_PIXEL = 1'b0,
    CMD_DRAIN = 1'b1
  } kind_e;

  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
  } pix_t;

  // one classified word for the back end; mask bit k selects window column
  // or row k (column 0 oldest, row 0 two lines up)
  typedef struct packed {
    kind_e            kind;
    logic             first;
    logic [COL_W-1:0] addr;
    pix_t             pix;
    logic [2:0]       rows;
    logic             emit_a;
    logic [2:0]       cols_a;
    logic [COL_W-1:0] col_a;
    logic             last_a;
    logic             fend_a;
    logic             emit_b;
    logic [2:0]       cols_b;
    logic [COL_W-1:0] col_b;
    logic [ROW_W-1:0] out_row;
  } cmd_t;

endpackage

`default_nettype wire

@@ hdl/bblur_if.sv @@
// pixel input and blurred result channel interfaces
`default_nettype none

interface bblur_in_if;
  logic                      valid;
  logic                      ready;
  logic                      func;
  logic [bblur_pkg::CH_W-1:0] red_in;
  logic [bblur_pkg::CH_W-1:0] green_in;
  logic [bblur_pkg::CH_W-1:0] blue_in;

  modport source (output valid, func, red_in, green_in, blue_in, input ready);
  modport sink   (input valid, func, red_in, green_in, blue_in, output ready);
endinterface

interface bblur_out_if;
  logic                        valid;
  logic                        ready;
  logic [bblur_pkg::CH_W-1:0]  red_out;
  logic [bblur_pkg::CH_W-1:0]  green_out;
  logic [bblur_pkg::CH_W-1:0]  blue_out;
  logic [bblur_pkg::ROW_W-1:0] out_row;
  logic [bblur_pkg::COL_W-1:0] out_col;
  logic                        last_in_run;
  logic                        frame_end;

  modport source (output valid, red_out, green_out, blue_out, out_row, out_col,
                  last_in_run, frame_end, input ready);
  modport sink   (input valid, red_out, green_out, blue_out, out_row, out_col,
                  last_in_run, frame_end, output ready);
endinterface

`default_nettype wire

@@ hdl/bblur_ram.sv @@
// generic simple dual port ram with registered read
`default_nettype none

module bblur_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 1024,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

@@ hdl/bblur_front.sv @@
// front end: config registers, raster position tracking, word classification
`default_nettype none

module bblur_front (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  bblur_in_if.sink                         pix_i,
  input  logic                             cfg_we_i,
  input  logic [bblur_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [bblur_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                             q_full_i,
  output logic                             q_push_o,
  output bblur_pkg::cmd_t                  q_cmd_o
);

  localparam int WID_W = bblur_pkg::WID_W;
  localparam int HGT_W = bblur_pkg::HGT_W;
  localparam int COL_W = bblur_pkg::COL_W;
  localparam int ROW_W = bblur_pkg::ROW_W;

  logic [WID_W-1:0] width_q;
  logic [HGT_W-1:0] height_q;
  logic [COL_W-1:0] col_q, col_d;
  logic [ROW_W-1:0] row_q, row_d;
  logic             draining_q, draining_d;
  logic [COL_W-1:0] drain_q, drain_d;

  logic [WID_W-1:0] w_eff, w_last, drain_ext;
  logic [HGT_W-1:0] h_eff, h_last;
  logic             is_drain, fire, row_end, frame_last, drain_end, right_ok;
  bblur_pkg::cmd_t  cmd;

  // out of range sizes clamp to 1..max
  assign w_eff = (width_q == '0) ? WID_W'(1) :
                 (width_q > WID_W'(bblur_pkg::MAX_WIDTH)) ? WID_W'(bblur_pkg::MAX_WIDTH) :
                 width_q;
  assign h_eff = (height_q == '0) ? HGT_W'(1) :
                 (height_q > HGT_W'(bblur_pkg::MAX_HEIGHT)) ? HGT_W'(bblur_pkg::MAX_HEIGHT) :
                 height_q;
  assign w_last = w_eff - WID_W'(1);
  assign h_last = h_eff - HGT_W'(1);

  assign pix_i.ready = !q_full_i;
  assign fire        = pix_i.valid && pix_i.ready;
  assign is_drain    = (pix_i.func == bblur_pkg::FUNC_DRAIN);

  assign row_end    = WID_W'(col_q) >= w_last;
  assign frame_last = HGT_W'(row_q) >= h_last;
  assign drain_ext  = WID_W'(drain_q);
  assign drain_end  = drain_ext >= w_last;
  assign right_ok   = (drain_ext + WID_W'(1)) < w_eff;

  // words that do not fit the current mode are taken and dropped
  assign q_push_o = fire && (is_drain == draining_q);
  assign q_cmd_o  = cmd;

  always_comb begin
    cmd           = '0;
    cmd.pix.red   = pix_i.red_in;
    cmd.pix.green = pix_i.green_in;
    cmd.pix.blue  = pix_i.blue_in;
    if (is_drain) begin
      cmd.kind    = bblur_pkg::CMD_DRAIN;
      cmd.first   = (drain_q == '0);
      cmd.addr    = drain_q + COL_W'(1);
      cmd.rows    = {1'b0, 1'b1, h_eff >= HGT_W'(2)};
      cmd.emit_a  = 1'b1;
      cmd.cols_a  = {right_ok, 1'b1, drain_q != '0};
      cmd.col_a   = drain_q;
      cmd.last_a  = 1'b1;
      cmd.fend_a  = drain_end;
      cmd.out_row = h_last[ROW_W-1:0];
    end else begin
      cmd.kind    = bblur_pkg::CMD_PIXEL;
      cmd.addr    = col_q;
      cmd.rows    = {1'b1, 1'b1, row_q >= ROW_W'(2)};
      cmd.emit_a  = (row_q != '0) && (col_q != '0);
      cmd.cols_a  = {1'b1, 1'b1, col_q >= COL_W'(2)};
      cmd.col_a   = col_q - COL_W'(1);
      cmd.last_a  = !row_end;
      cmd.emit_b  = (row_q != '0) && row_end;
      cmd.cols_b  = {1'b1, col_q != '0, 1'b0};
      cmd.col_b   = col_q;
      cmd.out_row = row_q - ROW_W'(1);
    end
  end

  always_comb begin
    col_d      = col_q;
    row_d      = row_q;
    draining_d = draining_q;
    drain_d    = drain_q;
    if (q_push_o) begin
      if (is_drain) begin
        if (drain_end) begin
          draining_d = 1'b0;
          drain_d    = '0;
        end else begin
          drain_d = drain_q + COL_W'(1);
        end
      end else if (row_end) begin
        col_d = '0;
        if (frame_last) begin
          row_d      = '0;
          draining_d = 1'b1;
          drain_d    = '0;
        end else begin
          row_d = row_q + ROW_W'(1);
        end
      end else begin
        col_d = col_q + COL_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q    <= WID_W'(1024);
      height_q   <= HGT_W'(1024);
      col_q      <= '0;
      row_q      <= '0;
      draining_q <= 1'b0;
      drain_q    <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          bblur_pkg::REG_FRAME_WIDTH:  width_q  <= cfg_data_i[WID_W-1:0];
          bblur_pkg::REG_FRAME_HEIGHT: height_q <= cfg_data_i[HGT_W-1:0];
          default: ;
        endcase
      end
      col_q      <= col_d;
      row_q      <= row_d;
      draining_q <= draining_d;
      drain_q    <= drain_d;
    end
  end

endmodule

`default_nettype wire

@@ hdl/bblur_fifo.sv @@
// two entry command queue between front and back end
`default_nettype none

module bblur_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  bblur_pkg::cmd_t cmd_i,
  output logic            full_o,
  input  logic            pop_i,
  output bblur_pkg::cmd_t cmd_o,
  output logic            valid_o
);

  localparam int QD  = bblur_pkg::QD;
  localparam int QAW = bblur_pkg::QAW;

  bblur_pkg::cmd_t  mem_q [QD];
  logic [QAW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [QAW:0]     cnt_q, cnt_d;

  assign full_o  = (cnt_q == (QAW+1)'(QD));
  assign valid_o = (cnt_q != '0);
  assign cmd_o   = mem_q[rd_ptr_q];

  always_comb begin
    case ({push_i, pop_i})
      2'b10:   cnt_d = cnt_q + (QAW+1)'(1);
      2'b01:   cnt_d = cnt_q - (QAW+1)'(1);
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == QAW'(QD - 1)) ? '0 : wr_ptr_q + QAW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == QAW'(QD - 1)) ? '0 : rd_ptr_q + QAW'(1);
      end
    end
  end

endmodule

`default_nettype wire

@@ hdl/bblur_back.sv @@
// back end: line stores, 3x3 window, masked sums and rounded divide
`default_nettype none

module bblur_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            q_valid_i,
  input  bblur_pkg::cmd_t q_cmd_i,
  output logic            q_pop_o,
  bblur_out_if.source     blur_o
);

  localparam int COL_W  = bblur_pkg::COL_W;
  localparam int ROW_W  = bblur_pkg::ROW_W;
  localparam int CH_W   = bblur_pkg::CH_W;
  localparam int PIX_W  = bblur_pkg::PIX_W;
  localparam int SUM_W  = bblur_pkg::SUM_W;
  localparam int CNT_W  = bblur_pkg::CNT_W;
  localparam int DIV_W  = bblur_pkg::DIV_W;
  localparam int PROD_W = bblur_pkg::PROD_W;
  localparam int RCP_SH = bblur_pkg::RCP_SH;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_LOAD = 4'b0010,
    ST_SUM  = 4'b0100,
    ST_MUL  = 4'b1000
  } state_e;

  typedef struct packed {
    bblur_pkg::pix_t  pix;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic             last;
    logic             fend;
  } res_t;

  state_e           state_q, state_d;
  bblur_pkg::cmd_t  cmd_q;
  logic             pre_q, sel_b_q;
  bblur_pkg::pix_t  win_q [3][3];
  logic [SUM_W-1:0] sum_q [3];
  logic [SUM_W-1:0] sum_d [3];
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [DIV_W-1:0] dvd [3];
  logic [PROD_W-1:0] prod [3];
  logic             out_valid_q;
  res_t             out_q, res_d;

  logic             win_shift, ram_we, out_load, res_free;
  logic [COL_W-1:0] raddr;
  logic [PIX_W-1:0] top_rd, mid_rd;
  logic [2:0]       mask_cols;

  // row r-2 and row r-1 line stores
  bblur_ram #(.WIDTH(PIX_W), .DEPTH(bblur_pkg::MAX_WIDTH)) u_top_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (cmd_q.addr),
    .wdata_i (mid_rd),
    .raddr_i (raddr),
    .rdata_o (top_rd)
  );

  bblur_ram #(.WIDTH(PIX_W), .DEPTH(bblur_pkg::MAX_WIDTH)) u_mid_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (cmd_q.addr),
    .wdata_i (cmd_q.pix),
    .raddr_i (raddr),
    .rdata_o (mid_rd)
  );

  assign res_free = !out_valid_q || blur_o.ready;

  // sequencer
  always_comb begin
    state_d   = state_q;
    q_pop_o   = 1'b0;
    raddr     = cmd_q.addr;
    win_shift = 1'b0;
    ram_we    = 1'b0;
    out_load  = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        raddr = q_cmd_i.first ? '0 : q_cmd_i.addr;
        if (q_valid_i) begin
          q_pop_o = 1'b1;
          state_d = ST_LOAD;
        end
      end
      ST_LOAD: begin
        win_shift = 1'b1;
        ram_we    = (cmd_q.kind == bblur_pkg::CMD_PIXEL);
        if (pre_q) begin
          state_d = ST_LOAD;
        end else if (cmd_q.emit_a || cmd_q.emit_b) begin
          state_d = ST_SUM;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_SUM: begin
        state_d = ST_MUL;
      end
      ST_MUL: begin
        if (res_free) begin
          out_load = 1'b1;
          state_d  = (!sel_b_q && cmd_q.emit_b) ? ST_SUM : ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // masked window sums
  always_comb begin
    mask_cols = sel_b_q ? cmd_q.cols_b : cmd_q.cols_a;
    cnt_d     = '0;
    for (int ch = 0; ch < 3; ch++) begin
      sum_d[ch] = '0;
    end
    for (int i = 0; i < 3; i++) begin
      for (int k = 0; k < 3; k++) begin
        if (cmd_q.rows[i] && mask_cols[k]) begin
          cnt_d = cnt_d + CNT_W'(1);
          for (int ch = 0; ch < 3; ch++) begin
            sum_d[ch] = sum_d[ch] + SUM_W'(win_q[k][i][PIX_W-1-ch*CH_W -: CH_W]);
          end
        end
      end
    end
  end

  // round half up: (2s + n) / (2n) through a reciprocal multiply
  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      dvd[ch]  = {sum_q[ch], 1'b0} + DIV_W'(cnt_q);
      prod[ch] = PROD_W'(dvd[ch]) * PROD_W'(bblur_pkg::RCP_TAB[cnt_q]);
    end
    res_d.pix.red   = prod[0][RCP_SH +: CH_W];
    res_d.pix.green = prod[1][RCP_SH +: CH_W];
    res_d.pix.blue  = prod[2][RCP_SH +: CH_W];
    res_d.row       = cmd_q.out_row;
    res_d.col       = sel_b_q ? cmd_q.col_b : cmd_q.col_a;
    res_d.last      = sel_b_q ? 1'b1 : cmd_q.last_a;
    res_d.fend      = sel_b_q ? 1'b0 : cmd_q.fend_a;
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      cmd_q <= q_cmd_i;
    end
    if (win_shift) begin
      for (int i = 0; i < 3; i++) begin
        win_q[0][i] <= win_q[1][i];
        win_q[1][i] <= win_q[2][i];
      end
      win_q[2][0] <= top_rd;
      win_q[2][1] <= mid_rd;
      win_q[2][2] <= cmd_q.pix;
    end
    if (state_q == ST_SUM) begin
      sum_q <= sum_d;
      cnt_q <= cnt_d;
    end
    if (out_load) begin
      out_q <= res_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      pre_q       <= 1'b0;
      sel_b_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (q_pop_o) begin
        pre_q   <= q_cmd_i.first;
        sel_b_q <= !q_cmd_i.emit_a;
      end else if (state_q == ST_LOAD) begin
        pre_q <= 1'b0;
      end else if (out_load) begin
        sel_b_q <= 1'b1;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (blur_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign blur_o.valid       = out_valid_q;
  assign blur_o.red_out     = out_q.pix.red;
  assign blur_o.green_out   = out_q.pix.green;
  assign blur_o.blue_out    = out_q.pix.blue;
  assign blur_o.out_row     = out_q.row;
  assign blur_o.out_col     = out_q.col;
  assign blur_o.last_in_run = out_q.last;
  assign blur_o.frame_end   = out_q.fend;

`ifndef SYNTHESIS
  a_cnt_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SUM) |-> (cnt_d != '0))
    else $error("empty neighborhood mask");

  a_quot_fits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_MUL) |-> (prod[0][PROD_W-1:RCP_SH+CH_W] == '0) &&
                            (prod[1][PROD_W-1:RCP_SH+CH_W] == '0) &&
                            (prod[2][PROD_W-1:RCP_SH+CH_W] == '0))
    else $error("mean exceeds channel range");

  a_fend_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.fend) |-> out_q.last)
    else $error("frame end on a non-final word");

  a_second_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && !res_d.last) |=> (state_q == ST_SUM) && sel_b_q)
    else $error("row end word not scheduled");
`endif

endmodule

`default_nettype wire

@@ hdl/box_blur_3x3_rgb.sv @@
// top level of the edge-normalized 3x3 rgb box blur
// usage:
//   pix_i carries one raster-order rgb pixel per word (func = pixel) or a
//   drain beat (func = drain); blur_o carries one blurred pixel per word with
//   its row and column, a last_in_run flag and a frame_end flag.
//   frame_width and frame_height are written through cfg_we_i / cfg_idx_i /
//   cfg_data_i while the block is idle.
// timing:
//   the front end takes one word per cycle into a two entry command queue
//   while the queue is not full. the back end sequencer finishes each word
//   before it takes the next: line store read, window load (repeated for
//   the first drain beat of a frame), then masked sum and reciprocal
//   multiply for each result, two at a row end; a word with no result ends
//   after the window load. each result is held in the output register.
// reset:
//   counters, queue and output valid clear; sizes return to 1024 x 1024.
//   line stores are not cleared and need no clearing pass.
// stall:
//   the output register holds while blur_o.ready is low; the sequencer then
//   waits, the queue fills and pix_i.ready drops.
`default_nettype none

module box_blur_3x3_rgb (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  bblur_in_if.sink                         pix_i,
  bblur_out_if.source                      blur_o,
  input  logic                             cfg_we_i,
  input  logic [bblur_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [bblur_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  // front to queue
  logic            push, full;
  bblur_pkg::cmd_t push_cmd;

  // queue to back
  logic            pop, q_valid;
  bblur_pkg::cmd_t head_cmd;

  // classify words, track raster position and drain column
  bblur_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .pix_i      (pix_i),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .q_full_i   (full),
    .q_push_o   (push),
    .q_cmd_o    (push_cmd)
  );

  // decouples word intake from the multi-cycle back end
  bblur_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (push_cmd),
    .full_o  (full),
    .pop_i   (pop),
    .cmd_o   (head_cmd),
    .valid_o (q_valid)
  );

  // line stores, window and averaging
  bblur_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_valid_i (q_valid),
    .q_cmd_i   (head_cmd),
    .q_pop_o   (pop),
    .blur_o    (blur_o)
  );

endmodule

`default_nettype wire

@@ tb/box_blur_3x3_rgb_test.sv @@
`timescale 1ns / 100ps
// self-checking regression of the 3x3 rgb box blur against a bit-true blur predictor

module box_blur_3x3_rgb_test;

  localparam int QUIET_CYCLES = 40;       // block latency plus a full command queue
  localparam int RANDOM_WORDS = 1700;     // useful words in the random part
  localparam int MAX_REPORTS  = 40;
  localparam int HOLD_CYCLES  = 400;      // long receiver hold-off
  localparam int HOLD_EVERY   = 600;      // results between hold-offs

  // one input word as the sender offers it
  typedef struct packed {
    logic            func;
    bblur_pkg::pix_t pix;
  } pix_word_t;

  // one blurred output word
  typedef struct packed {
    bblur_pkg::pix_t             pix;
    logic [bblur_pkg::ROW_W-1:0] row;
    logic [bblur_pkg::COL_W-1:0] col;
    logic                        last_in_run;
    logic                        frame_end;
  } blur_res_t;

  // 3x3 neighborhood, entry 3*i+k is row i (0 top) and column k (0 left)
  typedef bblur_pkg::pix_t [0:8] nbhd_t;

  // receiver ready patterns
  typedef enum logic [1:0] {
    RX_OPEN,
    RX_COIN,
    RX_SLOW,
    RX_COMB
  } rx_mode_e;

  logic                             clk_i = 1'b0;
  logic                             rst_ni;
  logic                             cfg_we_i;
  logic [bblur_pkg::CFG_IDX_W-1:0]  cfg_idx_i;
  logic [bblur_pkg::CFG_DATA_W-1:0] cfg_data_i;

  bblur_in_if  pix_if ();
  bblur_out_if blur_if ();

  box_blur_3x3_rgb u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .pix_i      (pix_if),
    .blur_o     (blur_if),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  // 8 ns clock
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // blur predictor: its own copy of line stores, window, counters and sizes
  // ---------------------------------------------------------------------------
  bblur_pkg::pix_t             prev_line  [bblur_pkg::MAX_WIDTH];  // row r-1
  bblur_pkg::pix_t             older_line [bblur_pkg::MAX_WIDTH];  // row r-2
  nbhd_t                       win;
  int                          at_row;
  int                          at_col;
  int                          drain_pos;
  bit                          in_drain;
  logic [bblur_pkg::WID_W-1:0] width_reg;
  logic [bblur_pkg::HGT_W-1:0] height_reg;
  blur_res_t                   blurred_q [$];           // blurred words still to come

  // register value as the block uses it: zero acts as one, above max as max
  function automatic int clamp_size(int v, int top);
    if (v < 1) return 1;
    if (v > top) return top;
    return v;
  endfunction

  // per-channel mean rounded half up
  function automatic logic [bblur_pkg::CH_W-1:0] round_mean(int sum, int n);
    return bblur_pkg::CH_W'((2 * sum + n) / (2 * n));
  endfunction

  // average over the neighbors selected by the row and column masks
  function automatic bblur_pkg::pix_t box_mean(nbhd_t nb, logic [2:0] rows,
                                               logic [2:0] cols);
    int              sr;
    int              sg;
    int              sb;
    int              n;
    bblur_pkg::pix_t m;
    sr = 0;
    sg = 0;
    sb = 0;
    n  = 0;
    for (int i = 0; i < 3; i++)
      for (int k = 0; k < 3; k++)
        if (rows[i] && cols[k]) begin
          sr += nb[3*i+k].red;
          sg += nb[3*i+k].green;
          sb += nb[3*i+k].blue;
          n++;
        end
    if (n == 0) return '0;
    m.red   = round_mean(sr, n);
    m.green = round_mean(sg, n);
    m.blue  = round_mean(sb, n);
    return m;
  endfunction

  // advance the predictor by one accepted word, queue the blurred words it causes
  task automatic blur_step(pix_word_t w);
    int              wd;
    int              ht;
    int              c;
    int              r;
    bblur_pkg::pix_t a;
    bblur_pkg::pix_t b;
    nbhd_t           nb;
    logic            row_end;
    logic [2:0]      rows;
    blur_res_t       res;
    wd = clamp_size(int'(width_reg), bblur_pkg::MAX_WIDTH);
    ht = clamp_size(int'(height_reg), bblur_pkg::MAX_HEIGHT);
    if (w.func == bblur_pkg::FUNC_DRAIN) begin
      // drain beat outside the drain is dropped
      if (!in_drain) return;
      // last row from the line stores, nothing below it
      nb = '0;
      for (int k = 0; k < 3; k++)
        if (drain_pos + k >= 1 && drain_pos + k - 1 < bblur_pkg::MAX_WIDTH) begin
          nb[k]     = older_line[drain_pos + k - 1];
          nb[3 + k] = prev_line[drain_pos + k - 1];
        end
      res.pix = box_mean(nb, {1'b0, 1'b1, ht >= 2},
                         {drain_pos + 1 < wd, 1'b1, drain_pos >= 1});
      res.row         = bblur_pkg::ROW_W'(ht - 1);
      res.col         = bblur_pkg::COL_W'(drain_pos);
      res.last_in_run = 1'b1;
      res.frame_end   = (drain_pos >= wd - 1);
      blurred_q.push_back(res);
      if (res.frame_end) begin
        in_drain  = 1'b0;
        drain_pos = 0;
      end else begin
        drain_pos++;
      end
    end else begin
      // pixel during the drain is dropped and leaves no trace
      if (in_drain) return;
      c = at_col;
      r = at_row;
      a = older_line[c];
      b = prev_line[c];
      older_line[c] = b;
      prev_line[c]  = w.pix;
      for (int i = 0; i < 3; i++) begin
        win[3*i]   = win[3*i+1];
        win[3*i+1] = win[3*i+2];
      end
      win[2]  = a;
      win[5]  = b;
      win[8]  = w.pix;
      row_end = (c >= wd - 1);
      rows    = {2'b11, r >= 2};
      if (r >= 1) begin
        if (c >= 1) begin
          res.pix         = box_mean(win, rows, {2'b11, c >= 2});
          res.row         = bblur_pkg::ROW_W'(r - 1);
          res.col         = bblur_pkg::COL_W'(c - 1);
          res.last_in_run = !row_end;
          res.frame_end   = 1'b0;
          blurred_q.push_back(res);
        end
        // right edge pixel of the row above comes out with the row end
        if (row_end) begin
          res.pix         = box_mean(win, rows, {1'b1, c >= 1, 1'b0});
          res.row         = bblur_pkg::ROW_W'(r - 1);
          res.col         = bblur_pkg::COL_W'(c);
          res.last_in_run = 1'b1;
          res.frame_end   = 1'b0;
          blurred_q.push_back(res);
        end
      end
      if (row_end) begin
        at_col = 0;
        if (r >= ht - 1) begin
          at_row    = 0;
          in_drain  = 1'b1;
          drain_pos = 0;
        end else begin
          at_row = r + 1;
        end
      end else begin
        at_col = c + 1;
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // stimulus bookkeeping
  // ---------------------------------------------------------------------------
  pix_word_t pend_q [$];     // words waiting for the driver
  int        words_queued;
  int        words_taken;
  int        useful_words;   // words that take part in a frame
  int        fail_count;

  task automatic queue_word(logic func, bblur_pkg::pix_t pix);
    pend_q.push_back(pix_word_t'{func, pix});
    words_queued++;
  endtask

  // random pixel, or one with every channel at 0 or 255
  function automatic bblur_pkg::pix_t any_pixel(bit extreme);
    bblur_pkg::pix_t p;
    if (extreme) begin
      p.red   = $urandom_range(0, 1) ? '1 : '0;
      p.green = $urandom_range(0, 1) ? '1 : '0;
      p.blue  = $urandom_range(0, 1) ? '1 : '0;
    end else begin
      p = bblur_pkg::PIX_W'($urandom);
    end
    return p;
  endfunction

  // wait until every word is taken and every blurred word is back, then let
  // the back end finish any word that causes no result
  task automatic settle();
    while (pend_q.size() != 0 || words_taken != words_queued || blurred_q.size() != 0)
      @(posedge clk_i);
    repeat (QUIET_CYCLES) @(posedge clk_i);
  endtask

  // register write, predictor copy follows at once
  task automatic write_size(logic [bblur_pkg::CFG_IDX_W-1:0] idx, int value);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= bblur_pkg::CFG_DATA_W'(value);
    if (idx == bblur_pkg::REG_FRAME_WIDTH) width_reg = bblur_pkg::WID_W'(value);
    else height_reg = bblur_pkg::HGT_W'(value);
  endtask

  task automatic set_frame(int w, int h);
    write_size(bblur_pkg::REG_FRAME_WIDTH, w);
    write_size(bblur_pkg::REG_FRAME_HEIGHT, h);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // one whole frame at the current size, then its drain beats; with noise,
  // stray drain beats land among the pixels and stray pixels in the drain
  task automatic stream_frame(bit noisy);
    int wd;
    int ht;
    int pause_at;
    bit extreme;
    wd       = clamp_size(int'(width_reg), bblur_pkg::MAX_WIDTH);
    ht       = clamp_size(int'(height_reg), bblur_pkg::MAX_HEIGHT);
    pause_at = ($urandom_range(0, 7) == 0) ? int'($urandom_range(0, wd * ht - 1)) : -1;
    extreme  = ($urandom_range(0, 5) == 0);
    for (int p = 0; p < wd * ht; p++) begin
      // let the block run dry in the middle of a frame
      if (p == pause_at) settle();
      if (noisy && $urandom_range(0, 19) == 0)
        queue_word(bblur_pkg::FUNC_DRAIN, any_pixel(1'b0));
      queue_word(bblur_pkg::FUNC_PIXEL, any_pixel(extreme));
    end
    for (int d = 0; d < wd; d++) begin
      if (noisy && $urandom_range(0, 9) == 0)
        queue_word(bblur_pkg::FUNC_PIXEL, any_pixel(1'b0));
      queue_word(bblur_pkg::FUNC_DRAIN, any_pixel(1'b0));
    end
    // drain beat after the frame is done
    if (noisy && $urandom_range(0, 3) == 0)
      queue_word(bblur_pkg::FUNC_DRAIN, any_pixel(1'b0));
    useful_words += wd * ht + wd;
  endtask

  // mostly small sizes, now and then a wider one or a zero
  function automatic int pick_size(int span);
    case ($urandom_range(0, 9))
      0:       return 0;
      1, 2:    return $urandom_range(1, span);
      default: return $urandom_range(1, 6);
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // driver: pending words go out in bursts with random gaps between them
  // ---------------------------------------------------------------------------
  pix_word_t on_wire;
  int        burst_left;
  int        gap_left;

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      pix_if.valid <= 1'b0;
      burst_left = 0;
      gap_left   = 0;
    end else begin
      if (pix_if.valid && pix_if.ready) begin
        blur_step(on_wire);
        words_taken++;
      end
      // an offered word stays put until taken
      if (pix_if.ready || !pix_if.valid) begin
        if (gap_left > 0) begin
          gap_left--;
          pix_if.valid <= 1'b0;
        end else if (pend_q.size() != 0) begin
          on_wire = pend_q.pop_front();
          pix_if.valid    <= 1'b1;
          pix_if.func     <= on_wire.func;
          pix_if.red_in   <= on_wire.pix.red;
          pix_if.green_in <= on_wire.pix.green;
          pix_if.blue_in  <= on_wire.pix.blue;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            // long bursts give stretches with no idling at all
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                     : $urandom_range(0, 30);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end
        end else begin
          pix_if.valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: checks each blurred word and stalls on a pattern of its own
  // ---------------------------------------------------------------------------
  rx_mode_e  rx_mode;
  int        mode_left;
  int        hold_left;
  int        results_seen;
  int        next_hold;
  blur_res_t got;
  blur_res_t want;

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      blur_if.ready <= 1'b0;
      rx_mode   = RX_OPEN;
      mode_left = 0;
      hold_left = 0;
      next_hold = 150;
    end else begin
      if (blur_if.valid && blur_if.ready) begin
        got.pix         = {blur_if.red_out, blur_if.green_out, blur_if.blue_out};
        got.row         = blur_if.out_row;
        got.col         = blur_if.out_col;
        got.last_in_run = blur_if.last_in_run;
        got.frame_end   = blur_if.frame_end;
        results_seen++;
        if (blurred_q.size() == 0) begin
          fail_count++;
          if (fail_count <= MAX_REPORTS)
            $display("%0t: unexpected word: expected none, got rgb %h row %0d col %0d",
                     $time, got.pix, got.row, got.col);
        end else begin
          want = blurred_q.pop_front();
          if (got.pix !== want.pix || got.row !== want.row || got.col !== want.col ||
              got.last_in_run !== want.last_in_run || got.frame_end !== want.frame_end) begin
            fail_count++;
            if (fail_count <= MAX_REPORTS)
              $display("%0t: mismatch: expected rgb %h row %0d col %0d last %b end %b, %s",
                       $time, want.pix, want.row, want.col, want.last_in_run,
                       want.frame_end, $sformatf("got rgb %h row %0d col %0d last %b end %b",
                       got.pix, got.row, got.col, got.last_in_run, got.frame_end));
          end
        end
      end
      // every so often a long hold-off so the block backs up into its input
      if (results_seen >= next_hold) begin
        hold_left = HOLD_CYCLES;
        next_hold += HOLD_EVERY;
      end
      if (mode_left == 0) begin
        rx_mode   = rx_mode_e'($urandom_range(0, 3));
        mode_left = $urandom_range(20, 300);
      end else begin
        mode_left--;
      end
      if (hold_left > 0) begin
        hold_left--;
        blur_if.ready <= 1'b0;
      end else begin
        case (rx_mode)
          RX_OPEN: blur_if.ready <= 1'b1;
          RX_COIN: blur_if.ready <= 1'($urandom_range(0, 1));
          RX_SLOW: blur_if.ready <= ($urandom_range(0, 3) == 0);
          default: blur_if.ready <= (mode_left % 3 != 0);
        endcase
      end
    end
  end

  // ---------------------------------------------------------------------------
  // test sequence
  // ---------------------------------------------------------------------------
  initial begin
    // every input known from time zero
    rst_ni          = 1'b0;
    cfg_we_i        = 1'b0;
    cfg_idx_i       = bblur_pkg::REG_FRAME_WIDTH;
    cfg_data_i      = '0;
    pix_if.valid    = 1'b0;
    pix_if.func     = bblur_pkg::FUNC_PIXEL;
    pix_if.red_in   = '0;
    pix_if.green_in = '0;
    pix_if.blue_in  = '0;
    blur_if.ready   = 1'b0;

    // predictor in its reset state
    foreach (prev_line[i]) begin
      prev_line[i]  = '0;
      older_line[i] = '0;
    end
    win          = '0;
    at_row       = 0;
    at_col       = 0;
    drain_pos    = 0;
    in_drain     = 1'b0;
    width_reg    = bblur_pkg::WID_W'(1024);
    height_reg   = bblur_pkg::HGT_W'(1024);
    words_queued = 0;
    words_taken  = 0;
    useful_words = 0;
    fail_count   = 0;
    results_seen = 0;

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // both sizes written as zero: a single-pixel image
    set_frame(0, 0);
    queue_word(bblur_pkg::FUNC_DRAIN, '1);   // drain beat before any frame, dropped
    queue_word(bblur_pkg::FUNC_PIXEL, '1);   // the whole image, all channels full
    queue_word(bblur_pkg::FUNC_PIXEL, '0);   // pixel while draining, dropped
    queue_word(bblur_pkg::FUNC_DRAIN, '0);   // bottom right corner, frame end
    queue_word(bblur_pkg::FUNC_DRAIN, '1);   // drain beat after the frame, dropped
    settle();

    // 3x3 checkerboard of full and empty channels: half-up rounding on every edge
    set_frame(3, 3);
    for (int r = 0; r < 3; r++)
      for (int c = 0; c < 3; c++)
        queue_word(bblur_pkg::FUNC_PIXEL,
                   bblur_pkg::pix_t'{((r + c) % 2) ? 8'hFF : 8'h00,
                                     ((r + c) % 2) ? 8'h00 : 8'hFF,
                                     bblur_pkg::CH_W'(31 * (3 * r + c))});
    for (int d = 0; d < 3; d++) queue_word(bblur_pkg::FUNC_DRAIN, '0);
    settle();

    // random frames, new sizes only between frames with the block idle
    useful_words = 0;
    set_frame(pick_size(40), pick_size(16));
    while (useful_words < RANDOM_WORDS) begin
      if ($urandom_range(0, 2) == 0) begin
        settle();
        set_frame(pick_size(40), pick_size(16));
      end
      stream_frame(1'b1);
    end
    settle();

    if (fail_count == 0) begin
      $display("box_blur_3x3_rgb regression: pass");
    end else begin
      $display("box_blur_3x3_rgb regression: fail");
    end
    $finish;
  end

  // run limit, far beyond the slowest correct run
  initial begin
    #8000000;
    $display("box_blur_3x3_rgb regression: fail");
    $finish;
  end

endmodule
